>>> rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int ANGLE_BITS_DEFAULT = 16;
  localparam int COUNT_W            = 32;
  localparam int HEAD_W             = 16;
  localparam int POS_W              = 48;
  localparam int DPC_W              = 24;
  localparam int IN_DATA_W          = 80;
  localparam int OUT_DATA_W         = 112;

  localparam logic [DPC_W-1:0]  DPC_RESET = 24'd41836;
  // cordic start vector, gain-compensated, q30
  localparam logic signed [31:0] CORDIC_K0 = 32'sd652032874;

  typedef struct packed {
    logic capture;
    logic diff;
    logic sum;
    logic absval;
    logic mul_p;
    logic rot_step;
    logic quad;
    logic mag;
    logic mul_lo;
    logic mul_hi;
    logic comb;
    logic sat;
    logic axis;
    logic set_heading;
    logic publish;
  } ddo_cmd_t;

  typedef struct packed {
    logic rot_last;
  } ddo_sts_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // table entry rounded to ab bits per turn
  function automatic logic [31:0] atan_step(input int unsigned idx, input int unsigned ab);
    logic [32:0] rnd;
    rnd = {1'b0, atan_entry(idx)} + (33'd1 << (31 - ab));
    return 32'(rnd >> (32 - ab));
  endfunction

endpackage

>>> rtl/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer for the odometry datapath and the output valid flag.
// ----------------------------------------------------------------------------
module ddo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  ddo_pkg::ddo_sts_t sts,
  output ddo_pkg::ddo_cmd_t cmd
);
  import ddo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SUM, S_ABS, S_MULP, S_ROT, S_QUAD, S_MAG,
    S_LO, S_HI, S_COMB, S_SAT, S_HEAD, S_FIN
  } state_t;

  state_t state;
  logic   axis;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.axis        = axis;
    cmd.capture     = (state == S_IDLE) && in_valid;
    cmd.diff        = (state == S_DIFF);
    cmd.sum         = (state == S_SUM);
    cmd.absval      = (state == S_ABS);
    cmd.mul_p       = (state == S_MULP);
    cmd.rot_step    = (state == S_ROT);
    cmd.quad        = (state == S_QUAD);
    cmd.mag         = (state == S_MAG);
    cmd.mul_lo      = (state == S_LO);
    cmd.mul_hi      = (state == S_HI);
    cmd.comb        = (state == S_COMB);
    cmd.sat         = (state == S_SAT);
    cmd.set_heading = (state == S_HEAD);
    cmd.publish     = (state == S_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= in_op ? S_HEAD : S_DIFF;
          end
        end
        S_DIFF: state <= S_SUM;
        S_SUM:  state <= S_ABS;
        S_ABS:  state <= S_MULP;
        S_MULP: state <= S_ROT;
        S_ROT: begin
          if (sts.rot_last) begin
            state <= S_QUAD;
          end
        end
        S_QUAD: state <= S_MAG;
        S_MAG: begin
          axis  <= 1'b0;
          state <= S_LO;
        end
        S_LO:   state <= S_HI;
        S_HI:   state <= S_COMB;
        S_COMB: state <= S_SAT;
        S_SAT: begin
          if (!axis) begin
            axis  <= 1'b1;
            state <= S_LO;
          end else begin
            state <= S_FIN;
          end
        end
        S_HEAD: state <= S_FIN;
        S_FIN: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/ddo_datapath.sv
// ----------------------------------------------------------------------------
// ddo_datapath
// Count deltas, iterative cordic, shared multiplier and saturating position.
// ----------------------------------------------------------------------------
module ddo_datapath #(
  parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ddo_pkg::DPC_W-1:0]       cfg_wr_data,
  input  logic [ddo_pkg::IN_DATA_W-1:0]   in_data,
  output logic [ddo_pkg::OUT_DATA_W-1:0]  out_data,
  input  ddo_pkg::ddo_cmd_t               cmd,
  output ddo_pkg::ddo_sts_t               sts
);
  import ddo_pkg::*;

  localparam int RW    = ANGLE_BITS + 2;
  localparam int CNT_W = $clog2(ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 3));
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // architectural state
  logic [DPC_W-1:0]          dpc;
  logic [COUNT_W-1:0]        last_left, last_right;
  logic signed [POS_W-1:0]   pos_x, pos_y;
  logic [HEAD_W-1:0]         heading;

  // working registers
  logic [COUNT_W-1:0]        in_left, in_right;
  logic [HEAD_W-1:0]         in_head;
  logic [COUNT_W-1:0]        dl, dr;
  logic signed [COUNT_W:0]   s_sum;
  logic [COUNT_W:0]          s_mag;
  logic                      s_neg;
  logic [55:0]               mag_p;
  logic signed [31:0]        cx, cy;
  logic signed [RW-1:0]      r;
  logic [1:0]                quadrant;
  logic [CNT_W-1:0]          iter;
  logic signed [31:0]        cos_r, sin_r;
  logic [31:0]               cmag, smag;
  logic                      cneg, sneg;
  logic [62:0]               lo;
  logic [54:0]               hi;
  logic [56:0]               m;
  logic [POS_W-1:0]          out_x, out_y;
  logic [HEAD_W-1:0]         out_h;

  // heading rescale and quadrant split
  logic [39:0]               a_ext;
  logic [ANGLE_BITS-1:0]     a, qa, r0;
  logic [1:0]                q0;

  assign a_ext = {heading, 24'b0} >> (40 - ANGLE_BITS);
  assign a     = a_ext[ANGLE_BITS-1:0];
  assign qa    = a + EIGHTH;
  assign q0    = qa[ANGLE_BITS-1 -: 2];
  assign r0    = a - {q0, {(ANGLE_BITS-2){1'b0}}};

  // rounded step table
  logic [RW-1:0] step_rom [ANGLE_BITS];
  for (genvar g = 0; g < ANGLE_BITS; g++) begin : g_step
    assign step_rom[g] = RW'(atan_step(g, ANGLE_BITS));
  end

  logic signed [31:0] xs, ys;
  logic signed [RW-1:0] step_cur;
  assign xs       = cx >>> iter;
  assign ys       = cy >>> iter;
  assign step_cur = signed'(step_rom[iter]);
  assign sts.rot_last = (iter == CNT_W'(ANGLE_BITS - 1));

  // shared unsigned multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b, tmag;
  logic [64:0] prod;
  assign tmag = cmd.axis ? smag : cmag;

  always_comb begin
    priority if (cmd.mul_p) begin
      mul_a = s_mag;
      mul_b = {8'b0, dpc};
    end else if (cmd.mul_hi) begin
      mul_a = 33'(mag_p[55:32]);
      mul_b = tmag;
    end else begin
      mul_a = {1'b0, mag_p[31:0]};
      mul_b = tmag;
    end
  end
  assign prod = 65'(mul_a) * 65'(mul_b);

  // saturating accumulate
  logic signed [POS_W-1:0] pos_sel;
  logic                    d_neg;
  logic signed [58:0]      acc;
  logic signed [POS_W-1:0] acc_sat;
  assign pos_sel = cmd.axis ? pos_y : pos_x;
  assign d_neg   = s_neg ^ (cmd.axis ? sneg : cneg);
  assign acc     = d_neg ? (59'(pos_sel) - signed'({2'b0, m}))
                         : (59'(pos_sel) + signed'({2'b0, m}));

  always_comb begin
    if ((&acc[58:POS_W-1]) || !(|acc[58:POS_W-1])) begin
      acc_sat = acc[POS_W-1:0];
    end else begin
      acc_sat = acc[58] ? POS_MIN : POS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dpc        <= DPC_RESET;
      last_left  <= '0;
      last_right <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
      heading    <= '0;
    end else begin
      if (cfg_wr_en) begin
        dpc <= cfg_wr_data;
      end
      if (cmd.diff) begin
        last_left  <= in_left;
        last_right <= in_right;
      end
      if (cmd.set_heading) begin
        heading <= in_head;
      end
      if (cmd.sat) begin
        if (cmd.axis) begin
          pos_y <= acc_sat;
        end else begin
          pos_x <= acc_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_left  <= in_data[31:0];
      in_right <= in_data[63:32];
      in_head  <= in_data[79:64];
    end
    if (cmd.diff) begin
      dl       <= in_left - last_left;
      dr       <= in_right - last_right;
      cx       <= CORDIC_K0;
      cy       <= '0;
      r        <= {{2{r0[ANGLE_BITS-1]}}, r0};
      quadrant <= q0;
      iter     <= '0;
    end
    if (cmd.sum) begin
      s_sum <= {dl[COUNT_W-1], dl} + {dr[COUNT_W-1], dr};
    end
    if (cmd.absval) begin
      s_neg <= s_sum[COUNT_W];
      s_mag <= s_sum[COUNT_W] ? -s_sum : s_sum;
    end
    if (cmd.mul_p) begin
      mag_p <= prod[55:0];
    end
    if (cmd.rot_step) begin
      if (r >= 0) begin
        cx <= cx - ys;
        cy <= cy + xs;
        r  <= r - step_cur;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        r  <= r + step_cur;
      end
      iter <= iter + 1'b1;
    end
    if (cmd.quad) begin
      unique case (quadrant)
        2'd0: begin cos_r <= cx;  sin_r <= cy;  end
        2'd1: begin cos_r <= -cy; sin_r <= cx;  end
        2'd2: begin cos_r <= -cx; sin_r <= -cy; end
        2'd3: begin cos_r <= cy;  sin_r <= -cx; end
        default: begin cos_r <= cx; sin_r <= cy; end
      endcase
    end
    if (cmd.mag) begin
      cneg <= cos_r[31];
      cmag <= cos_r[31] ? -cos_r : cos_r;
      sneg <= sin_r[31];
      smag <= sin_r[31] ? -sin_r : sin_r;
    end
    if (cmd.mul_lo) begin
      lo <= prod[62:0];
    end
    if (cmd.mul_hi) begin
      hi <= prod[54:0];
    end
    if (cmd.comb) begin
      // floor(|p|*|t| / 2^31) from the two partial products
      m <= 57'({hi, 1'b0}) + 57'(lo[62:31]);
    end
    if (cmd.publish) begin
      out_x <= pos_x;
      out_y <= pos_y;
      out_h <= heading;
    end
  end

  assign out_data = {out_h, out_y, out_x};

endmodule

>>> rtl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning odometry: wheel counts and external heading to X/Y position.
// ----------------------------------------------------------------------------
//   channel   direction  fields (low bit up)
//   s_axis    in         tdata: left_count, right_count, heading_angle
//                        tuser: operation
//   m_axis    out        tdata: pos_x, pos_y, heading_out
//   cfg       in         wr_data: distance_per_count
//
// an encoder item must pass the cordic loop (one iteration per cycle) and
// the single shared multiplier, used five times, before the next transfer;
// a heading item only loads the heading and publishes it.
// synchronous reset clears position, counts and heading and loads the
// default distance per count. a result waiting on m_axis stalls the block
// only at its final step, so the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ddo_pkg::DPC_W-1:0]       cfg_wr_data,   // distance_per_count
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // left_count, right_count, heading_angle
  input  logic [ddo_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tuser,  // operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pos_x, pos_y, heading_out
  output logic [ddo_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import ddo_pkg::*;

  ddo_cmd_t cmd;
  ddo_sts_t sts;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  ddo_datapath #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_axis_tdata),
    .out_data    (m_axis_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

`ifndef SYNTH
  // one item in flight: ready drops right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register loaded while occupied");

  a_valid_from_publish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.publish))
    else $error("output valid without a publish step");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.diff, cmd.sum, cmd.absval, cmd.mul_p, cmd.rot_step,
              cmd.quad, cmd.mag, cmd.mul_lo, cmd.mul_hi, cmd.comb, cmd.sat,
              cmd.set_heading, cmd.publish}))
    else $error("more than one datapath step issued");
`endif

endmodule
